// ===== hdl/mcct_pkg.sv =====
// Shared types, constants and tables for the marching cubes cell triangulator.
package mcct_pkg;

	localparam int GRID_DIM   = 1024;
	localparam int CELL_W     = 10;
	localparam int VAL_W      = 32;
	localparam int STEP_W     = 31;
	localparam int POS_W      = 45;
	localparam int DIFF_W     = VAL_W + 1;
	localparam int PROD_W     = DIFF_W + STEP_W;
	localparam int QUOT_W     = STEP_W;
	localparam int GRID_CMP_W = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int MAX_VERTS  = 15;
	localparam int VCNT_W     = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_ISO      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_Z   = 3'd6;

	localparam logic [STEP_W-1:0] STEP_RESET = 31'd65536;

	typedef struct packed {
		logic [VAL_W-1:0]             iso;
		logic [2:0][VAL_W-1:0]        origin;
		logic [2:0][STEP_W-1:0]       step;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_SETUP,
		ST_MUL,
		ST_DIVS,
		ST_DIVW,
		ST_FIN,
		ST_OUT
	} state_t;

	// corner offsets as {z, y, x}
	localparam logic [2:0] CORNER_OFF [8] = '{
		3'b000, 3'b001, 3'b011, 3'b010, 3'b100, 3'b101, 3'b111, 3'b110
	};

	// edge end corners as {a, b}
	localparam logic [5:0] EDGE_ENDS [12] = '{
		{3'd0, 3'd1}, {3'd1, 3'd2}, {3'd2, 3'd3}, {3'd3, 3'd0},
		{3'd4, 3'd5}, {3'd5, 3'd6}, {3'd6, 3'd7}, {3'd7, 3'd4},
		{3'd0, 3'd4}, {3'd1, 3'd5}, {3'd2, 3'd6}, {3'd3, 3'd7}
	};

	// each row: a leading F marker, then the cut edges, first edge highest
	localparam logic [63:0] TRI_ROWS [256] = '{
	64'hF, 64'hF083, 64'hF019, 64'hF183981, 64'hF12a, 64'hF08312a, 64'hF92a029, 64'hF2832a8a98,
	64'hF3b2, 64'hF0b28b0, 64'hF19023b, 64'hF1b219b98b, 64'hF3a1ba3, 64'hF0a108a8ba,
	64'hF3903b9ba9, 64'hF98aa8b,
	64'hF478, 64'hF430734, 64'hF019847, 64'hF419471731, 64'hF12a847, 64'hF34730412a,
	64'hF92a902847, 64'hF2a9297273794,
	64'hF8473b2, 64'hFb47b24204, 64'hF90184723b, 64'hF47b94b9b2921, 64'hF3a13ba784,
	64'hF1ba14b1047b4, 64'hF47890b9bab03, 64'hF47b4b99ba,
	64'hF954, 64'hF954083, 64'hF054150, 64'hF854835315, 64'hF12a954, 64'hF30812a495,
	64'hF52a542402, 64'hF2a5325354348,
	64'hF95423b, 64'hF0b208b495, 64'hF05401523b, 64'hF21525828b485, 64'hFa3ba13954,
	64'hF4950818a18ba, 64'hF54050b5bab03, 64'hF54858aa8b,
	64'hF978579, 64'hF930953573, 64'hF078017157, 64'hF153357, 64'hF978957a12,
	64'hFa12950530573, 64'hF802825857a52, 64'hF2a5253357,
	64'hF7957893b2, 64'hF95797292027b, 64'hF23b018178157, 64'hFb21b17715,
	64'hF958857a13a3b, 64'hF5705097b010aba0, 64'hFba0b03a50807570, 64'hFba57b5,
	64'hFa65, 64'hF0835a6, 64'hF9015a6, 64'hF1831985a6, 64'hF165261, 64'hF165126308,
	64'hF965906026, 64'hF598582526328,
	64'hF23ba65, 64'hFb08b20a65, 64'hF01923b5a6, 64'hF5a61929b298b, 64'hF63b653513,
	64'hF08b0b50515b6, 64'hF3b6036065059, 64'hF65969bb98,
	64'hF5a6478, 64'hF43047365a, 64'hF1905a6847, 64'hFa65197173794, 64'hF612651478,
	64'hF125526304347, 64'hF847905065026, 64'hF739794329596269,
	64'hF3b2784a65, 64'hF5a647242027b, 64'hF01947823b5a6, 64'hF9219b294b7b45a6,
	64'hF8473b53515b6, 64'hF51b5b610b7b404b, 64'hF059065036b63847, 64'hF65969b4797b9,
	64'hFa4964a, 64'hF4a649a083, 64'hFa01a60640, 64'hF83181686461a, 64'hF149124264,
	64'hF308129249264, 64'hF024426, 64'hF832824426,
	64'hFa49a64b23, 64'hF08228b49a4a6, 64'hF3b201606461a, 64'hF64161a48121b8b1,
	64'hF964936913b63, 64'hF8b1810b61914641, 64'hF3b6360064, 64'hF648b68,
	64'hF7a678a89a, 64'hF0730a709a67a, 64'hFa671a7178180, 64'hFa67a71173,
	64'hF126168189867, 64'hF269291679093739, 64'hF780706602, 64'hF732672,
	64'hF23ba68a89867, 64'hF20727b09767a9a7, 64'hF1801781a767a23b, 64'hFb21b17a61671,
	64'hF896867916b63136, 64'hF091b67, 64'hF7807063b0b60, 64'hF7b6,
	64'hF76b, 64'hF308b76, 64'hF019b76, 64'hF819831b76, 64'hFa126b7, 64'hF12a3086b7,
	64'hF2902a96b7, 64'hF6b72a3a83a98,
	64'hF723627, 64'hF708760620, 64'hF276237019, 64'hF162186198876, 64'hFa76a17137,
	64'hFa7617a187108, 64'hF03707a0a96a7, 64'hF76a7a88a9,
	64'hF684b86, 64'hF36b306046, 64'hF86b846901, 64'hF946963931b36, 64'hF6846b82a1,
	64'hF12a30b06b046, 64'hF4b846b0292a9, 64'hFa93a32943b36463,
	64'hF823842462, 64'hF042462, 64'hF190234246438, 64'hF194142246, 64'hF8138618466a1,
	64'hFa10a06604, 64'hF4634386a3039a93, 64'hFa946a4,
	64'hF49576b, 64'hF083495b76, 64'hF50154076b, 64'hFb76834354315, 64'hF954a1276b,
	64'hF6b712a083495, 64'hF76b54a42a402, 64'hF348354325a52b76,
	64'hF723762549, 64'hF954086062687, 64'hF362376150540, 64'hF628687218485158,
	64'hF954a16176137, 64'hF16a176107870954, 64'hF40a4a503a6a737a, 64'hF76a7a854a48a,
	64'hF6956b9b89, 64'hF36b063056095, 64'hF0b805b01556b, 64'hF6b3635531,
	64'hF12a95b9b8b56, 64'hF0b306b09656912a, 64'hFb85b56805a52025, 64'hF6b36352a3a53,
	64'hF589528562382, 64'hF956960062, 64'hF158180568382628, 64'hF156216,
	64'hF13616a386569896, 64'hFa10a06950560, 64'hF03856a, 64'hFa56,
	64'hFb5a75b, 64'hFb5ab75830, 64'hF5b75ab190, 64'hFa75ab7981831, 64'hFb12b71751,
	64'hF08312717572b, 64'hF9759279022b7, 64'hF75272b592328982,
	64'hF25a235375, 64'hF820852875a25, 64'hF9015a35373a2, 64'hF982921872a25752,
	64'hF135375, 64'hF087071175, 64'hF903935537, 64'hF987597,
	64'hF5845a8ab8, 64'hF5045b05abb30, 64'hF01984a8aba45, 64'hFab4a45b34941314,
	64'hF2512852b8458, 64'hF04b0b345b2b151b, 64'hF0250592b5458b85, 64'hF9452b3,
	64'hF25a352345384, 64'hF5a2524420, 64'hF3a235a385458019, 64'hF5a2524192942,
	64'hF845853351, 64'hF045105, 64'hF845853905035, 64'hF945,
	64'hF4b749b9ab, 64'hF0834979b79ab, 64'hF1ab1b414074b, 64'hF3143481a474bab4,
	64'hF4b79b492b912, 64'hF9749b791b2b1083, 64'hFb74b42240, 64'hFb74b42834324,
	64'hF29a279237749, 64'hF9a7974a27870207, 64'hF37a3a274a1a040a, 64'hF1a2874,
	64'hF491417713, 64'hF491417081871, 64'hF403743, 64'hF487,
	64'hF9a8ab8, 64'hF30939bb9a, 64'hF01a0a88ab, 64'hF31ab3a, 64'hF12b1b99b8,
	64'hF30939b1292b9, 64'hF02b80b, 64'hF32b,
	64'hF23828aa89, 64'hF9a2092, 64'hF23828a0181a8, 64'hF1a2, 64'hF138918, 64'hF091,
	64'hF038, 64'hF
	};

	function automatic logic [VCNT_W-1:0] row_len(input logic [63:0] row);
		logic [VCNT_W-1:0] len;
		len = '0;
		for (int k = 0; k < 16; k++) begin
			if (row[4*k +: 4] != 4'd0) begin
				len = VCNT_W'(k);
			end
		end
		return len;
	endfunction

endpackage

// ===== hdl/marching_cubes_cell_triangulator.sv =====
// Top level: cell intake, sequencer and vertex datapath of the cell triangulator.
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    cell_x..z, corner_value_0..7
//  out      output     out_valid/out_ready  vertex_x..z, last_vertex
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// A cell passes the intake state and the corner base products, one axis at a
// time; a vertex then passes SETUP, MUL, DIVS, DIVW (divider wait), FIN and OUT,
// or only SETUP, FIN and OUT when its edge needs no interpolation. Up to 15 vertices a cell.
// Reset clears the sequencer; configuration returns to its reset values.
// A stalled vertex holds the sequencer until its transfer.
module marching_cubes_cell_triangulator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mcct_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mcct_pkg::VAL_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [mcct_pkg::CELL_W-1:0]           cell_x,
	input  logic [mcct_pkg::CELL_W-1:0]           cell_y,
	input  logic [mcct_pkg::CELL_W-1:0]           cell_z,
	input  logic signed [mcct_pkg::VAL_W-1:0]     corner_value_0,
	input  logic signed [mcct_pkg::VAL_W-1:0]     corner_value_1,
	input  logic signed [mcct_pkg::VAL_W-1:0]     corner_value_2,
	input  logic signed [mcct_pkg::VAL_W-1:0]     corner_value_3,
	input  logic signed [mcct_pkg::VAL_W-1:0]     corner_value_4,
	input  logic signed [mcct_pkg::VAL_W-1:0]     corner_value_5,
	input  logic signed [mcct_pkg::VAL_W-1:0]     corner_value_6,
	input  logic signed [mcct_pkg::VAL_W-1:0]     corner_value_7,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [mcct_pkg::VAL_W-1:0]     vertex_x,
	output logic signed [mcct_pkg::VAL_W-1:0]     vertex_y,
	output logic signed [mcct_pkg::VAL_W-1:0]     vertex_z,
	output logic                                  last_vertex
);
	import mcct_pkg::*;

	localparam logic signed [POS_W-1:0] SAT_MAX = POS_W'(64'sd2147483647);
	localparam logic signed [POS_W-1:0] SAT_MIN = -POS_W'(64'sd2147483648);

	cfg_t cfg;

	state_t state_q, state_d;

	logic [VAL_W-1:0]          in_val [8];
	logic [CELL_W-1:0]         in_cell [3];
	logic [7:0]                cube;
	logic                      cell_bad;

	logic [VAL_W-1:0]          val_q [8];
	logic [CELL_W-1:0]         cell_q [3];
	logic [63:0]               row_q;
	logic [VCNT_W-1:0]         len_q;
	logic [VCNT_W-1:0]         vcnt_q;
	logic [1:0]                ax_q;
	logic signed [POS_W-1:0]   base_q [3];
	logic signed [POS_W-1:0]   p1_q [3];
	logic signed [POS_W-1:0]   p2_q [3];
	logic [1:0]                axis_q;
	logic                      use_p2_q;
	logic                      interp_q;
	logic                      neg_q;
	logic [DIFF_W-1:0]         d1_mag_q;
	logic [DIFF_W-1:0]         dd_mag_q;
	logic [PROD_W-1:0]         num_q;
	logic [VAL_W-1:0]          vout_q [3];
	logic                      last_q;

	logic [DIFF_W-1:0]         mul_a;
	logic [STEP_W-1:0]         mul_b;
	logic [PROD_W-1:0]         mul_p;
	logic signed [POS_W-1:0]   base_new;

	logic [3:0]                nib_idx;
	logic [3:0]                edge_nib;
	logic [3:0]                edge_id;
	logic [2:0]                ca, cb;
	logic [2:0]                off_a, off_b, off_diff;
	logic [1:0]                axis;
	logic signed [VAL_W-1:0]   v1, v2, iso;
	logic signed [DIFF_W-1:0]  d1, dd;
	logic                      eq1, eq2, eq12, direct;
	logic                      is_last;

	logic                      div_start, div_done;
	logic [QUOT_W-1:0]         quot;
	logic signed [POS_W-1:0]   qs;
	logic signed [POS_W-1:0]   pf [3];

	mcct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mcct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (dd_mag_q),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		in_val[0]  = corner_value_0;
		in_val[1]  = corner_value_1;
		in_val[2]  = corner_value_2;
		in_val[3]  = corner_value_3;
		in_val[4]  = corner_value_4;
		in_val[5]  = corner_value_5;
		in_val[6]  = corner_value_6;
		in_val[7]  = corner_value_7;
		in_cell[0] = cell_x;
		in_cell[1] = cell_y;
		in_cell[2] = cell_z;
		iso        = $signed(cfg.iso);
		for (int l = 0; l < 8; l++) begin
			cube[l] = $signed(in_val[l]) < iso;
		end
		cell_bad = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (GRID_CMP_W'(in_cell[k]) >= GRID_CMP_W'(GRID_DIM)) begin
				cell_bad = 1'b1;
			end
		end
	end

	always_comb begin
		nib_idx  = len_q - vcnt_q - 1'b1;
		edge_nib = row_q[{nib_idx, 2'b00} +: 4];
		edge_id  = (edge_nib < 4'd12) ? edge_nib : 4'd0;
		ca       = EDGE_ENDS[edge_id][5:3];
		cb       = EDGE_ENDS[edge_id][2:0];
		off_a    = CORNER_OFF[ca];
		off_b    = CORNER_OFF[cb];
		off_diff = off_a ^ off_b;
		axis     = off_diff[0] ? 2'd0 : (off_diff[1] ? 2'd1 : 2'd2);
		v1       = $signed(val_q[ca]);
		v2       = $signed(val_q[cb]);
		d1       = DIFF_W'(iso) - DIFF_W'(v1);
		dd       = DIFF_W'(v2) - DIFF_W'(v1);
		eq1      = v1 == iso;
		eq2      = v2 == iso;
		eq12     = v1 == v2;
		direct   = eq1 || eq2 || eq12;
		is_last  = vcnt_q == (len_q - 1'b1);
	end

	always_comb begin
		if (state_q == ST_BASE) begin
			mul_a = DIFF_W'(cell_q[ax_q]);
			mul_b = cfg.step[ax_q];
		end else begin
			mul_a = d1_mag_q;
			mul_b = cfg.step[axis_q];
		end
		mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
		base_new = POS_W'($signed(cfg.origin[ax_q])) + $signed({1'b0, mul_p[POS_W-2:0]});
	end

	always_comb begin
		qs = neg_q ? -$signed(POS_W'(quot)) : $signed(POS_W'(quot));
		for (int k = 0; k < 3; k++) begin
			if (interp_q) begin
				pf[k] = (axis_q == 2'(k)) ? p1_q[k] + qs : p1_q[k];
			end else begin
				pf[k] = use_p2_q ? p2_q[k] : p1_q[k];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid && !cell_bad) state_d = ST_BASE;
			ST_BASE:  if (ax_q == 2'd2) state_d = (len_q == '0) ? ST_IDLE : ST_SETUP;
			ST_SETUP: state_d = direct ? ST_FIN : ST_MUL;
			ST_MUL:   state_d = ST_DIVS;
			ST_DIVS:  state_d = ST_DIVW;
			ST_DIVW:  if (div_done) state_d = ST_FIN;
			ST_FIN:   state_d = ST_OUT;
			ST_OUT:   if (out_ready) state_d = last_q ? ST_IDLE : ST_SETUP;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = state_q == ST_IDLE;
		out_valid = state_q == ST_OUT;
		div_start = state_q == ST_DIVS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q    <= '0;
			vcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				ax_q   <= '0;
				vcnt_q <= '0;
			end else if (state_q == ST_BASE) begin
				ax_q <= ax_q + 1'b1;
			end else if (state_q == ST_OUT && out_ready) begin
				vcnt_q <= vcnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			for (int l = 0; l < 8; l++) begin
				val_q[l] <= in_val[l];
			end
			for (int k = 0; k < 3; k++) begin
				cell_q[k] <= in_cell[k];
			end
			row_q <= TRI_ROWS[cube];
		end
		if (state_q == ST_BASE) begin
			base_q[ax_q] <= base_new;
			len_q        <= row_len(row_q);
		end
		if (state_q == ST_SETUP) begin
			for (int k = 0; k < 3; k++) begin
				p1_q[k] <= off_a[k] ? base_q[k] + POS_W'(cfg.step[k]) : base_q[k];
				p2_q[k] <= off_b[k] ? base_q[k] + POS_W'(cfg.step[k]) : base_q[k];
			end
			axis_q   <= axis;
			use_p2_q <= !eq1 && eq2;
			interp_q <= !direct;
			neg_q    <= d1[DIFF_W-1] ^ dd[DIFF_W-1] ^ off_a[axis];
			d1_mag_q <= d1[DIFF_W-1] ? DIFF_W'(-d1) : DIFF_W'(d1);
			dd_mag_q <= dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
			last_q   <= is_last;
		end
		if (state_q == ST_MUL) begin
			num_q <= mul_p;
		end
		if (state_q == ST_FIN) begin
			for (int k = 0; k < 3; k++) begin
				priority if (pf[k] > SAT_MAX) vout_q[k] <= SAT_MAX[VAL_W-1:0];
				else if (pf[k] < SAT_MIN)     vout_q[k] <= SAT_MIN[VAL_W-1:0];
				else                          vout_q[k] <= pf[k][VAL_W-1:0];
			end
		end
	end

	assign vertex_x    = $signed(vout_q[0]);
	assign vertex_y    = $signed(vout_q[1]);
	assign vertex_z    = $signed(vout_q[2]);
	assign last_vertex = last_q;

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a vertex waits");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVW)
		else $error("divider finished outside its wait state");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_vertex |=> in_ready)
		else $error("no return to intake after the final vertex");

	a_vcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SETUP |-> vcnt_q < len_q)
		else $error("vertex count past the row length");

endmodule

// ===== hdl/mcct_cfg.sv =====
// Configuration register file: threshold, grid origin and cell steps.
module mcct_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mcct_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcct_pkg::VAL_W-1:0]       cfg_data,
	output mcct_pkg::cfg_t                   cfg
);
	import mcct_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iso    <= '0;
			cfg_q.origin <= '0;
			cfg_q.step   <= {3{STEP_RESET}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ISO:      cfg_q.iso       <= cfg_data;
				CFG_ORIGIN_X: cfg_q.origin[0] <= cfg_data;
				CFG_ORIGIN_Y: cfg_q.origin[1] <= cfg_data;
				CFG_ORIGIN_Z: cfg_q.origin[2] <= cfg_data;
				CFG_STEP_X:   cfg_q.step[0]   <= cfg_data[STEP_W-1:0];
				CFG_STEP_Y:   cfg_q.step[1]   <= cfg_data[STEP_W-1:0];
				CFG_STEP_Z:   cfg_q.step[2]   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/mcct_div.sv =====
// Restoring divider, one quotient bit a cycle, quotient known to fit QUOT_W bits.
module mcct_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mcct_pkg::PROD_W-1:0]   num,
	input  logic [mcct_pkg::DIFF_W-1:0]   den,
	output logic                          done,
	output logic [mcct_pkg::QUOT_W-1:0]   quot
);
	import mcct_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W + 1);

	logic [DIFF_W-1:0] rem_q;
	logic [DIFF_W-1:0] den_q;
	logic [QUOT_W-1:0] lo_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DIFF_W:0]   trial;
	logic [DIFF_W:0]   diff;
	logic              take;

	always_comb begin
		trial = {rem_q, lo_q[QUOT_W-1]};
		diff  = trial - {1'b0, den_q};
		take  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(QUOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[PROD_W-1:QUOT_W];
			lo_q   <= num[QUOT_W-1:0];
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= take ? diff[DIFF_W-1:0] : trial[DIFF_W-1:0];
			lo_q   <= {lo_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== dv/tb_marching_cubes_cell_triangulator.sv =====
// Testbench for the marching cubes cell triangulator: directed and random cells checked against a vertex predictor.
module tb_marching_cubes_cell_triangulator;
	timeunit 1ns;
	timeprecision 1ps;
	import mcct_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VAL_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CELL_W-1:0] cell_x = '0, cell_y = '0, cell_z = '0;
	logic signed [VAL_W-1:0] cv [8] = '{default: '0};
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [VAL_W-1:0] vertex_x, vertex_y, vertex_z;
	logic last_vertex;

	longint iso_lvl;
	longint org [3];
	longint stp [3];
	vertex_t vertex_queue [$];
	int errors = 0;
	int cells_sent = 0;
	int vertices_seen = 0;
	int rx_hold = 0;
	int rx_gap = 0;
	bit no_idle = 1'b0;

	marching_cubes_cell_triangulator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
		.corner_value_0(cv[0]), .corner_value_1(cv[1]), .corner_value_2(cv[2]),
		.corner_value_3(cv[3]), .corner_value_4(cv[4]), .corner_value_5(cv[5]),
		.corner_value_6(cv[6]), .corner_value_7(cv[7]),
		.out_valid(out_valid), .out_ready(out_ready),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.last_vertex(last_vertex)
	);

	always #10 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// expected vertices of one accepted cell
	function automatic void triangulate_cell(logic [9:0] cx, logic [9:0] cy, logic [9:0] cz,
			logic signed [31:0] v [8]);
		logic [7:0] cube;
		logic [63:0] row;
		logic [3:0] e;
		logic [2:0] ca, cb;
		longint cell_idx [3];
		longint p1, p2, p, v1, v2;
		logic signed [31:0] pos [3];
		vertex_t vx;
		int n;
		cell_idx[0] = cx; cell_idx[1] = cy; cell_idx[2] = cz;
		cube = '0;
		for (int l = 0; l < 8; l++)
			if (longint'(v[l]) < iso_lvl) cube[l] = 1'b1;
		row = TRI_ROWS[cube];
		n = 0;
		for (int k = 0; k < 16; k++)
			if (row[4*k +: 4] == 4'hF) n = k;
		for (int i = 0; i < n; i++) begin
			e = row[4*(n-1-i) +: 4];
			ca = EDGE_ENDS[e][5:3];
			cb = EDGE_ENDS[e][2:0];
			v1 = v[ca];
			v2 = v[cb];
			for (int ax = 0; ax < 3; ax++) begin
				p1 = org[ax] + stp[ax] * (cell_idx[ax] + CORNER_OFF[ca][ax]);
				p2 = org[ax] + stp[ax] * (cell_idx[ax] + CORNER_OFF[cb][ax]);
				if (v1 == iso_lvl) p = p1;
				else if (v2 == iso_lvl) p = p2;
				else if (v1 == v2) p = p1;
				else p = p1 + ((iso_lvl - v1) * (p2 - p1)) / (v2 - v1);
				pos[ax] = sat32(p);
			end
			vx.x = pos[0]; vx.y = pos[1]; vx.z = pos[2];
			vx.last = (i == n - 1);
			vertex_queue = {vertex_queue, vx};
		end
	endfunction

	function automatic logic signed [31:0] corner_near(logic signed [31:0] lvl);
		case ($urandom_range(0, 9))
			0, 1: return lvl;
			2: return $urandom;
			3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return lvl + $signed($urandom_range(0, 131072)) - 32'sd65536;
		endcase
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			CFG_ISO: iso_lvl = $signed(data);
			CFG_ORIGIN_X: org[0] = $signed(data);
			CFG_ORIGIN_Y: org[1] = $signed(data);
			CFG_ORIGIN_Z: org[2] = $signed(data);
			CFG_STEP_X: stp[0] = data[30:0];
			CFG_STEP_Y: stp[1] = data[30:0];
			CFG_STEP_Z: stp[2] = data[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_cell(logic [9:0] cx, logic [9:0] cy, logic [9:0] cz,
			logic signed [31:0] v [8]);
		int g;
		cell_x = cx; cell_y = cy; cell_z = cz;
		cv = v;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		triangulate_cell(cx, cy, cz, v);
		cells_sent++;
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic send_random_cell();
		logic signed [31:0] v [8];
		logic signed [31:0] lvl;
		lvl = 32'(iso_lvl);
		for (int l = 0; l < 8; l++) v[l] = corner_near(lvl);
		send_cell(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
			10'($urandom_range(0, 1023)), v);
	endtask

	// wait out the remaining vertices plus the tail of an empty cell
	task automatic drain();
		in_valid = 1'b0;
		while (vertex_queue.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic test_reset_config();
		logic signed [31:0] v [8];
		v = '{default: 32'sd0};
		send_cell(10'd0, 10'd0, 10'd0, v);
		v = '{default: -32'sd1};
		send_cell(10'd1023, 10'd1023, 10'd1023, v);
		for (int l = 0; l < 8; l++) begin
			v = '{default: 32'sd65536};
			v[l] = -32'sd65536;
			send_cell(10'(l), 10'd512, 10'd1023, v);
		end
		v = '{32'sh80000000, 32'sh7fffffff, 32'sd0, -32'sd1, 32'sd1, 32'sh7fffffff,
			32'sh80000000, 32'sd0};
		send_cell(10'd3, 10'd5, 10'd7, v);
		v = '{-32'sd5, 32'sd5, -32'sd5, 32'sd5, 32'sd5, -32'sd5, 32'sd5, -32'sd5};
		send_cell(10'h2aa, 10'h155, 10'h3ff, v);
		v = '{-32'sd7, -32'sd7, 32'sd9, 32'sd9, -32'sd7, 32'sd3, 32'sd3, -32'sd7};
		send_cell(10'd100, 10'd200, 10'd300, v);
		drain();
	endtask

	task automatic test_register_extremes();
		logic signed [31:0] v [8];
		write_reg(CFG_ISO, 32'h7fffffff);
		write_reg(CFG_ORIGIN_X, 32'h7fffffff);
		write_reg(CFG_ORIGIN_Y, 32'h80000000);
		write_reg(CFG_ORIGIN_Z, 32'h0);
		write_reg(CFG_STEP_X, 32'hffffffff);
		write_reg(CFG_STEP_Y, 32'h7fffffff);
		write_reg(CFG_STEP_Z, 32'h0);
		write_reg(CFG_UNUSED, 32'h12345678);
		v = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, -32'sd1};
		send_cell(10'd1023, 10'd0, 10'd1023, v);
		send_cell(10'd0, 10'd1023, 10'd511, v);
		drain();
		write_reg(CFG_ISO, 32'h80000000);
		write_reg(CFG_ORIGIN_X, 32'h80000000);
		write_reg(CFG_ORIGIN_Y, 32'h7fffffff);
		write_reg(CFG_STEP_X, 32'h0);
		write_reg(CFG_STEP_Z, 32'h80001000);
		send_cell(10'd1023, 10'd1023, 10'd0, v);
		v = '{default: 32'sh80000000};
		send_cell(10'd1, 10'd2, 10'd3, v);
		drain();
		for (int ph = 0; ph < 3; ph++) begin
			write_reg(CFG_ISO, 32'sd65536 * ($signed($urandom_range(0, 8)) - 4));
			write_reg(CFG_ORIGIN_X, $urandom);
			write_reg(CFG_ORIGIN_Y, $urandom);
			write_reg(CFG_ORIGIN_Z, $urandom);
			write_reg(CFG_STEP_X, $urandom);
			write_reg(CFG_STEP_Y, $urandom_range(0, 1 << 20));
			write_reg(CFG_STEP_Z, {1'($urandom_range(0, 1)), 31'($urandom_range(0, 1 << 18))});
			repeat (4) send_random_cell();
			drain();
		end
	endtask

	task automatic test_random_cells();
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_ISO, ph == 3 ? $urandom : $urandom_range(0, 1 << 20) - (1 << 19));
			write_reg(CFG_ORIGIN_X, $urandom_range(0, 1 << 24) - (1 << 23));
			write_reg(CFG_ORIGIN_Y, $urandom_range(0, 1 << 24) - (1 << 23));
			write_reg(CFG_ORIGIN_Z, $urandom_range(0, 1 << 24) - (1 << 23));
			write_reg(CFG_STEP_X, $urandom_range(1, 1 << 17));
			write_reg(CFG_STEP_Y, $urandom_range(1, 1 << 17));
			write_reg(CFG_STEP_Z, $urandom_range(1, 1 << 17));
			no_idle = (ph == 1);
			repeat (30) send_random_cell();
			drain();
		end
		no_idle = 1'b0;
	endtask

	task automatic test_output_stall();
		rx_hold = 400;
		repeat (8) send_random_cell();
		drain();
	endtask

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_gap > 0) begin
			out_ready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else begin
			out_ready <= 1'b1;
			rx_gap <= gap_len();
		end
	end

	always @(posedge clk) begin
		vertex_t ev;
		if (arst_n && out_valid && out_ready) begin
			vertices_seen++;
			if (vertex_queue.size() == 0) begin
				$display("%0t: vertex with none expected: got %0d %0d %0d last %0b", $time,
					vertex_x, vertex_y, vertex_z, last_vertex);
				errors++;
			end else begin
				ev = vertex_queue.pop_front();
				if (vertex_x !== ev.x) begin
					$display("%0t: vertex_x expected %0d got %0d", $time, ev.x, vertex_x);
					errors++;
				end
				if (vertex_y !== ev.y) begin
					$display("%0t: vertex_y expected %0d got %0d", $time, ev.y, vertex_y);
					errors++;
				end
				if (vertex_z !== ev.z) begin
					$display("%0t: vertex_z expected %0d got %0d", $time, ev.z, vertex_z);
					errors++;
				end
				if (last_vertex !== ev.last) begin
					$display("%0t: last_vertex expected %0b got %0b", $time, ev.last,
						last_vertex);
					errors++;
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("marching_cubes_cell_triangulator verification failed");
		$finish;
	end

	initial begin
		iso_lvl = 0;
		for (int ax = 0; ax < 3; ax++) begin
			org[ax] = 0;
			stp[ax] = 65536;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_reset_config();
		test_register_extremes();
		test_random_cells();
		test_output_stall();
		if (vertex_queue.size() != 0) begin
			$display("%0t: %0d vertices never arrived", $time, vertex_queue.size());
			errors++;
		end
		$display("Covered %0d cells and %0d vertices over reset, extreme and random settings,",
			cells_sent, vertices_seen);
		$display("with random gaps on both channels and one long output hold.");
		if (errors == 0)
			$display("marching_cubes_cell_triangulator verification clean");
		else
			$display("marching_cubes_cell_triangulator verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/mcct_pkg.sv
hdl/mcct_cfg.sv
hdl/mcct_div.sv
hdl/marching_cubes_cell_triangulator.sv
dv/tb_marching_cubes_cell_triangulator.sv
